// ===== rtl/core/ffcp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ffcp_pkg;

	localparam int CharW    = 8;
	localparam int PosW     = 5;
	localparam int Deg7W    = 7;
	localparam int LonDegW  = 10;
	localparam int LonOutW  = 11;
	localparam int SecW     = 14;
	localparam int SeenW    = 6;

	localparam logic [PosW-1:0]  PosMax   = 5'd31;
	localparam logic [PosW-1:0]  PosSign  = 5'd10;
	localparam logic [PosW-1:0]  PosTerm  = 5'd20;

	localparam logic [CharW-1:0] ChMinus  = 8'h2D;
	localparam logic [CharW-1:0] ChSemi   = 8'h3B;
	localparam logic [CharW-1:0] ChZero   = 8'h30;
	localparam logic [CharW-1:0] ChNine   = 8'h39;

	localparam logic [SeenW-1:0] SeenAll  = 6'h3F;

	typedef struct packed {
		logic             valid;
		logic [CharW-1:0] char_code;
		logic             last;
	} beat_t;

	typedef struct packed {
		logic                       format_ok;
		logic        [Deg7W-1:0]    lat_degrees;
		logic        [Deg7W-1:0]    lat_minutes;
		logic        [SecW-1:0]     lat_seconds_centi;
		logic signed [LonOutW-1:0]  lon_degrees;
		logic        [Deg7W-1:0]    lon_minutes;
		logic        [SecW-1:0]     lon_seconds_centi;
	} result_t;

	typedef struct packed {
		logic valid;
		logic ready;
	} out_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/ffcp_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ffcp_in_stage (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire  [ffcp_pkg::CharW-1:0]   in_char,
	input  wire                          in_last,
	input  wire  ffcp_pkg::out_status_t  out_status,
	output ffcp_pkg::beat_t              beat
);
	import ffcp_pkg::*;

	logic             valid_s1;
	logic [CharW-1:0] char_s1;
	logic             last_s1;
	logic             advance;

	// hold a last beat while the result register is still occupied
	assign advance  = valid_s1 && !(last_s1 && out_status.valid && !out_status.ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= in_char;
			last_s1 <= in_last;
		end
	end

	assign beat.valid     = advance;
	assign beat.char_code = char_s1;
	assign beat.last      = last_s1;

endmodule

`default_nettype wire

// ===== rtl/core/ffcp_accum.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ffcp_accum (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire ffcp_pkg::beat_t beat,
	output logic                res_load,
	output ffcp_pkg::result_t   res
);
	import ffcp_pkg::*;

	logic [PosW-1:0]    pos_q;
	logic [Deg7W-1:0]   lat_deg_q, lat_min_q, lat_sw_q, lat_sf_q;
	logic [1:0]         lat_fc_q;
	logic               lon_neg_q;
	logic [LonDegW-1:0] lon_deg_q;
	logic [Deg7W-1:0]   lon_min_q, lon_sw_q, lon_sf_q;
	logic [1:0]         lon_fc_q;
	logic [SeenW-1:0]   seen_q;

	logic               is_digit;
	logic [3:0]         dval;
	logic               ok;

	function automatic logic [Deg7W-1:0] tta7(input logic [Deg7W-1:0] acc,
	                                          input logic [3:0] d);
		logic [Deg7W-1:0] t;
		t = (acc << 3) + (acc << 1);
		return t + Deg7W'(d);
	endfunction

	function automatic logic [LonDegW-1:0] tta10(input logic [LonDegW-1:0] acc,
	                                             input logic [3:0] d);
		logic [LonDegW-1:0] t;
		t = (acc << 3) + (acc << 1);
		return t + LonDegW'(d);
	endfunction

	function automatic logic [SecW-1:0] sec_centi(input logic [Deg7W-1:0] whole,
	                                              input logic [Deg7W-1:0] frac,
	                                              input logic [1:0] cnt);
		logic [SecW-1:0] w;
		logic [SecW-1:0] f;
		w = (SecW'(whole) << 6) + (SecW'(whole) << 5) + (SecW'(whole) << 2);
		case (cnt)
			2'd0:    f = '0;
			2'd1:    f = (SecW'(frac) << 3) + (SecW'(frac) << 1);
			default: f = SecW'(frac);
		endcase
		return w + f;
	endfunction

	assign is_digit = (beat.char_code >= ChZero) && (beat.char_code <= ChNine);
	assign dval     = is_digit ? beat.char_code[3:0] : 4'd0;

	// fields only change below the terminator, so the stored state is final here
	assign ok = (pos_q == PosTerm) && (beat.char_code == ChSemi) && (seen_q == SeenAll);

	assign res_load = beat.valid && beat.last;

	always_comb begin
		res = '0;
		if (ok) begin
			res.format_ok         = 1'b1;
			res.lat_degrees       = lat_deg_q;
			res.lat_minutes       = lat_min_q;
			res.lat_seconds_centi = sec_centi(lat_sw_q, lat_sf_q, lat_fc_q);
			res.lon_degrees       = lon_neg_q ? -$signed({1'b0, lon_deg_q})
			                                  : $signed({1'b0, lon_deg_q});
			res.lon_minutes       = lon_min_q;
			res.lon_seconds_centi = sec_centi(lon_sw_q, lon_sf_q, lon_fc_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			lat_deg_q <= '0;
			lat_min_q <= '0;
			lat_sw_q  <= '0;
			lat_sf_q  <= '0;
			lat_fc_q  <= '0;
			lon_neg_q <= 1'b0;
			lon_deg_q <= '0;
			lon_min_q <= '0;
			lon_sw_q  <= '0;
			lon_sf_q  <= '0;
			lon_fc_q  <= '0;
			seen_q    <= '0;
		end else if (beat.valid) begin
			if (beat.last) begin
				// frame done: start clean
				pos_q     <= '0;
				lat_deg_q <= '0;
				lat_min_q <= '0;
				lat_sw_q  <= '0;
				lat_sf_q  <= '0;
				lat_fc_q  <= '0;
				lon_neg_q <= 1'b0;
				lon_deg_q <= '0;
				lon_min_q <= '0;
				lon_sw_q  <= '0;
				lon_sf_q  <= '0;
				lon_fc_q  <= '0;
				seen_q    <= '0;
			end else begin
				if (pos_q != PosMax) begin
					pos_q <= pos_q + 1'b1;
				end
				if (pos_q == PosSign && beat.char_code == ChMinus) begin
					lon_neg_q <= 1'b1;
				end
				if (is_digit) begin
					case (pos_q)
						5'd2, 5'd3: begin
							lat_deg_q <= tta7(lat_deg_q, dval);
							seen_q[0] <= 1'b1;
						end
						5'd4, 5'd5: begin
							lat_min_q <= tta7(lat_min_q, dval);
							seen_q[1] <= 1'b1;
						end
						5'd6, 5'd7: begin
							lat_sw_q  <= tta7(lat_sw_q, dval);
							seen_q[2] <= 1'b1;
						end
						5'd8, 5'd9: begin
							lat_sf_q  <= tta7(lat_sf_q, dval);
							lat_fc_q  <= lat_fc_q + 1'b1;
							seen_q[2] <= 1'b1;
						end
						5'd11, 5'd12, 5'd13: begin
							lon_deg_q <= tta10(lon_deg_q, dval);
							seen_q[3] <= 1'b1;
						end
						5'd14, 5'd15: begin
							lon_min_q <= tta7(lon_min_q, dval);
							seen_q[4] <= 1'b1;
						end
						5'd16, 5'd17: begin
							lon_sw_q  <= tta7(lon_sw_q, dval);
							seen_q[5] <= 1'b1;
						end
						5'd18, 5'd19: begin
							lon_sf_q  <= tta7(lon_sf_q, dval);
							lon_fc_q  <= lon_fc_q + 1'b1;
							seen_q[5] <= 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/ffcp_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ffcp_out_reg (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     res_load,
	input  wire ffcp_pkg::result_t  res,
	input  wire                     out_ready,
	output logic                    out_valid,
	output ffcp_pkg::result_t       out_res,
	output ffcp_pkg::out_status_t   out_status
);
	import ffcp_pkg::*;

	logic    valid_q;
	result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	assign out_valid        = valid_q;
	assign out_res          = res_q;
	assign out_status.valid = valid_q;
	assign out_status.ready = out_ready;

endmodule

`default_nettype wire

// ===== rtl/core/fixed_frame_coordinate_parser_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Coordinate frame parser. Feed one ASCII character per beat on s_axis, with
// tlast on the final character; each frame yields one result beat on m_axis.
// A character is taken every cycle while s_axis_tready is high: it passes an
// input register, then the position decode and times-ten accumulate, and the
// last character of a frame loads the result register, which holds it for
// m_axis until it is read. s_axis_tready drops only while a last character
// waits on a result that is not yet read. The result is valid (tuser high)
// only for a 21-character frame with ';' at position 20 and a digit in every
// field; otherwise tuser is low and all values are zero. Seconds are in
// hundredths.
module fixed_frame_coordinate_parser_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // [7:0] char_code
	input  wire         s_axis_tlast,   // end_of_frame
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// [6:0] lat_degrees, [13:7] lat_minutes, [27:14] lat_seconds_centi,
	// [38:28] lon_degrees, [45:39] lon_minutes, [59:46] lon_seconds_centi, [63:60] zero
	output logic [63:0] m_axis_tdata,
	output logic        m_axis_tuser    // [0] format_ok
);
	import ffcp_pkg::*;

	beat_t       beat;
	out_status_t out_status;
	result_t     res;
	result_t     out_res;
	logic        res_load;

	ffcp_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_char    (s_axis_tdata),
		.in_last    (s_axis_tlast),
		.out_status (out_status),
		.beat       (beat)
	);

	ffcp_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.beat     (beat),
		.res_load (res_load),
		.res      (res)
	);

	ffcp_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_load   (res_load),
		.res        (res),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_res    (out_res),
		.out_status (out_status)
	);

	assign m_axis_tuser = out_res.format_ok;
	assign m_axis_tdata = {4'd0,
	                       out_res.lon_seconds_centi,
	                       out_res.lon_minutes,
	                       out_res.lon_degrees,
	                       out_res.lat_seconds_centi,
	                       out_res.lat_minutes,
	                       out_res.lat_degrees};

endmodule

`default_nettype wire
